@@ sv/npcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

    localparam int CHAN_W  = 8;
    localparam int CODE_W  = 15;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ENTRY_W = 3 * CHAN_W;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // Sideband that travels with each palette entry through the compare pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

@@ sv/npcs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/npcs_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npcs_match #(
    parameter int AW = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  npcs_pkg::color_t      target,
    input  npcs_pkg::color_t      entry,
    input  npcs_pkg::tag_t        entry_tag,
    input  wire logic [AW-1:0]    entry_idx,
    output logic                  done,
    output logic      [AW-1:0]    best_idx
);

    import npcs_pkg::*;

    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [AW-1:0]     idx_reg;
    tag_t              tag_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [AW-1:0]     best_idx_reg;
    logic              have_reg;
    logic              done_reg;

    logic [CHAN_W-1:0] dr, dg, db;
    logic [DIST_W-1:0] dist_sum;

    always_comb
    begin
        dr = (target.red   >= entry.red)   ? target.red - entry.red     : entry.red - target.red;
        dg = (target.green >= entry.green) ? target.green - entry.green : entry.green - target.green;
        db = (target.blue  >= entry.blue)  ? target.blue - entry.blue   : entry.blue - target.blue;
        dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

    // Stage one squares the channel differences; stage two sums and keeps the minimum.
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg <= SQ_W'(db) * SQ_W'(db);
        idx_reg  <= entry_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            have_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= entry_tag;
            done_reg <= tag_reg.valid && tag_reg.last;
            if (start)
            begin
                have_reg <= 1'b0;
            end
            else if (tag_reg.valid)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // A strict less-than keeps the lowest index among equal distances.
    always_ff @(posedge clk)
    begin
        if (tag_reg.valid && (!have_reg || dist_sum < best_dist_reg))
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= idx_reg;
        end
    end

    assign done     = done_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

@@ sv/nearest_palette_color_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Signals                      | Carries
// s       | in        | s_tvalid s_tready s_tdata    | palette write or color lookup
//         |           | s_tuser                      | op (0 write, 1 lookup)
// m       | out       | m_tvalid m_tready m_tdata    | best_index of one lookup
//
// A write item goes straight into the palette memory. A lookup reads the palette memory
// one entry per cycle, and its result is registered once the last entry has passed the
// compare pipeline; the next item can be accepted after that register is loaded.
// Reset clears the control state only; the palette is undefined until written.
// The result waits in the output register; a new item is accepted meanwhile, and a
// following lookup holds its result until that register is free.

module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: entry_index[7:0], entry_red[7:0], entry_green[7:0],
    // entry_blue[7:0], color_code[14:0], one zero pad bit
    input  wire logic [npcs_pkg::IN_W-1:0]  s_tdata,
    // s_tuser from bit 0: op
    input  wire logic [0:0]                 s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // m_tdata from bit 0: best_index[7:0]
    output logic      [npcs_pkg::OUT_W-1:0] m_tdata
);

    import npcs_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              issue_reg, issue_next;
    tag_t              rd_tag_reg;
    logic [AW-1:0]     rd_idx_reg;
    color_t            target_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic              accept;
    logic              lookup_start;
    logic              wr_en;
    logic [AW+7:0]     wr_wide;
    logic [CODE_W-1:0] code;
    logic [ENTRY_W-1:0] rd_data;
    color_t            entry;
    logic              match_done;
    logic [AW-1:0]     best_idx;
    logic [AW+7:0]     best_wide;
    logic              out_load;
    logic              scan_last;

    assign accept       = s_tvalid && s_tready;
    assign lookup_start = accept && (s_tuser[0] == OP_LOOKUP);
    assign wr_wide      = {{AW{1'b0}}, s_tdata[7:0]};
    assign wr_en        = accept && (s_tuser[0] == OP_WRITE)
                          && (wr_wide < (AW + 8)'(PALETTE_ENTRIES));
    assign code         = s_tdata[46:32];
    assign scan_last    = (addr_reg == AW'(PALETTE_ENTRIES - 1));
    assign entry        = color_t'(rd_data);
    assign best_wide    = {8'd0, best_idx};
    assign out_load     = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign s_tready     = (state_reg == ST_IDLE);

    // Entries are stored with red in the top byte and blue in the bottom byte.
    npcs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .clk    (clk),
        .we     (wr_en),
        .wr_addr(wr_wide[AW-1:0]),
        .wr_data({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
        .rd_en  (issue_reg),
        .rd_addr(addr_reg),
        .rd_data(rd_data)
    );

    npcs_match #(
        .AW(AW)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lookup_start),
        .target   (target_reg),
        .entry    (entry),
        .entry_tag(rd_tag_reg),
        .entry_idx(rd_idx_reg),
        .done     (match_done),
        .best_idx (best_idx)
    );

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        issue_next    = issue_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = ST_SCAN;
                    addr_next  = '0;
                    issue_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    addr_next = addr_reg + AW'(1);
                    if (scan_last)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (match_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            issue_reg    <= 1'b0;
            rd_tag_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            issue_reg        <= issue_next;
            rd_tag_reg.valid <= issue_reg;
            rd_tag_reg.last  <= issue_reg && scan_last;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Channels expand from five to eight bits as value * 8 + 4.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        if (lookup_start)
        begin
            target_reg.red   <= {code[4:0], 3'b100};
            target_reg.green <= {code[9:5], 3'b100};
            target_reg.blue  <= {code[14:10], 3'b100};
        end
        if (out_load)
        begin
            m_tdata_reg <= best_wide[7:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ tb/nearest_palette_color_search_tb.sv @@
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;

    import npcs_pkg::*;

    localparam int NUM_ENTRIES  = 256;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int TAIL_ITEMS   = 150;

    typedef struct packed {
        logic              pause;
        logic              op;
        logic [7:0]        slot;
        color_t            rgb;
        logic [CODE_W-1:0] code;
    } palette_req_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic [0:0]          s_tuser  = OP_WRITE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    palette_req_t        req_queue [$];
    palette_req_t        cur_req;
    logic [7:0]          expected_best [$];
    color_t              shadow_palette [NUM_ENTRIES];
    color_t              plan_palette [NUM_ENTRIES];

    int                  pct_choice [3] = '{0, 8, 35};
    int                  src_gap;
    int                  src_pct;
    int                  snk_gap;
    int                  snk_pct;
    int                  accepted_count;
    int                  lookups_sent;
    int                  results_seen;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  hold_left;
    logic                hold_used;
    logic                hold_off;
    logic                quiet_tail;
    logic                lookup_taken;
    logic                loaded;
    logic [7:0]          want_index;

    nearest_palette_color_search i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Each 5-bit channel widens to value*8+4; the lowest index at the minimum distance wins.
    function automatic logic [7:0] nearest_entry(input logic [CODE_W-1:0] code);
        int         want_r;
        int         want_g;
        int         want_b;
        int         dr;
        int         dg;
        int         db;
        int         dist_sum;
        int         best_dist;
        int         k;
        logic [7:0] best;
        want_r    = int'({code[4:0], 3'b100});
        want_g    = int'({code[9:5], 3'b100});
        want_b    = int'({code[14:10], 3'b100});
        best      = 8'd0;
        best_dist = 0;
        for (k = 0; k < NUM_ENTRIES; k++)
        begin
            dr       = want_r - int'(shadow_palette[k].red);
            dg       = want_g - int'(shadow_palette[k].green);
            db       = want_b - int'(shadow_palette[k].blue);
            dist_sum = dr * dr + dg * dg + db * db;
            if (k == 0 || dist_sum < best_dist)
            begin
                best      = k[7:0];
                best_dist = dist_sum;
            end
        end
        return best;
    endfunction

    function automatic color_t rgb_of(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        return {r, g, b};
    endfunction

    function automatic logic [CODE_W-1:0] code_near(input color_t c);
        return {c.blue[7:3], c.green[7:3], c.red[7:3]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // The unused fields of each item carry random noise that the block must ignore.
    task automatic push_write(input logic [7:0] slot, input color_t c);
        palette_req_t req;
        req.pause = 1'b0;
        req.op    = OP_WRITE;
        req.slot  = slot;
        req.rgb   = c;
        req.code  = CODE_W'($urandom_range(0, 32767));
        plan_palette[slot] = c;
        req_queue.push_back(req);
    endtask

    task automatic push_lookup(input logic [CODE_W-1:0] code);
        palette_req_t req;
        req.pause = 1'b0;
        req.op    = OP_LOOKUP;
        req.slot  = 8'($urandom_range(0, 255));
        req.rgb   = 24'($urandom_range(0, 24'hFFFFFF));
        req.code  = code;
        req_queue.push_back(req);
    endtask

    task automatic push_pause();
        palette_req_t req;
        req       = '0;
        req.pause = 1'b1;
        req_queue.push_back(req);
    endtask

    // Half writes, half lookups; many lookups aim at a stored color and many writes copy
    // an existing entry, so exact hits and ties come up often.
    task automatic run_random(input int count);
        int     n;
        int     pick;
        color_t c;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    c = 24'($urandom_range(0, 24'hFFFFFF));
                else if (pick < 7)
                    c = rgb_of({5'($urandom_range(0, 31)), 3'b100},
                               {5'($urandom_range(0, 31)), 3'b100},
                               {5'($urandom_range(0, 31)), 3'b100});
                else
                    c = plan_palette[$urandom_range(0, NUM_ENTRIES - 1)];
                push_write(8'($urandom_range(0, 255)), c);
            end
            else if ($urandom_range(0, 1) == 0)
                push_lookup(CODE_W'($urandom_range(0, 32767)));
            else
                push_lookup(code_near(plan_palette[$urandom_range(0, NUM_ENTRIES - 1)]));
        end
    endtask

    // Sender: tracks writes, predicts accepted lookups and loads the next item from the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid       <= 1'b0;
            s_tdata        <= '0;
            s_tuser        <= OP_WRITE;
            lookups_sent   <= 0;
            quiet_tail     <= 1'b0;
            src_gap        = 0;
            src_pct        = 0;
            accepted_count = 0;
        end
        else
        begin
            lookup_taken = 1'b0;
            if (s_tvalid && s_tready)
            begin
                accepted_count++;
                if (cur_req.op == OP_WRITE)
                    shadow_palette[cur_req.slot] = cur_req.rgb;
                else
                begin
                    expected_best.push_back(nearest_entry(cur_req.code));
                    lookup_taken = 1'b1;
                    lookups_sent <= lookups_sent + 1;
                end
                if (accepted_count % 50 == 0)
                    src_pct = pct_choice[$urandom_range(0, 2)];
            end
            quiet_tail <= (req_queue.size() < TAIL_ITEMS);
            if (!s_tvalid || s_tready)
            begin
                loaded = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (req_queue.size() > 0)
                begin
                    if (req_queue[0].pause)
                    begin
                        // Hold back until every lookup sent so far has returned its result.
                        if (!lookup_taken && lookups_sent == results_seen)
                            void'(req_queue.pop_front());
                    end
                    else if (!quiet_tail && $urandom_range(0, 99) < src_pct)
                        src_gap = $urandom_range(1, 9) - 1;
                    else
                    begin
                        cur_req = req_queue.pop_front();
                        loaded  = 1'b1;
                    end
                end
                s_tvalid <= loaded;
                if (loaded)
                begin
                    s_tdata <= {1'b0, cur_req.code, cur_req.rgb.blue, cur_req.rgb.green,
                                cur_req.rgb.red, cur_req.slot};
                    s_tuser <= cur_req.op;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expected index.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            results_seen <= 0;
            snk_gap      = 0;
            snk_pct      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_best.size() == 0)
                    report_mismatch($sformatf("unexpected result best_index=%0d", m_tdata));
                else
                begin
                    want_index = expected_best.pop_front();
                    if (m_tdata !== want_index)
                        report_mismatch($sformatf("best_index=%0d, expected %0d",
                                                  m_tdata, want_index));
                end
                if ((results_seen + 1) % 16 == 0)
                    snk_pct = pct_choice[$urandom_range(0, 2)];
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < snk_pct)
            begin
                snk_gap = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One long back-pressure stretch so that the output register and the input both stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (!hold_used && results_seen >= 30)
            begin
                hold_used = 1'b1;
                hold_left = 3000;
            end
            if (hold_left > 0)
                hold_left--;
            hold_off <= (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("nearest_palette_color_search_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int     k;
        color_t few [3];

        // Every slot holds the same gray first, so the first lookup is a full tie.
        for (k = 0; k < NUM_ENTRIES; k++)
            push_write(8'(k), rgb_of(8'h84, 8'h84, 8'h84));
        push_lookup({5'd16, 5'd16, 5'd16});
        push_write(8'd0, rgb_of(8'h00, 8'h00, 8'h00));
        push_write(8'd255, rgb_of(8'hFF, 8'hFF, 8'hFF));
        push_lookup(15'h0000);
        push_lookup(15'h7FFF);
        // Exact match, then a later duplicate (lower index keeps winning), then an earlier one.
        push_write(8'd128, rgb_of(8'd252, 8'd4, 8'd124));
        push_lookup({5'd15, 5'd0, 5'd31});
        push_write(8'd200, rgb_of(8'd252, 8'd4, 8'd124));
        push_lookup({5'd15, 5'd0, 5'd31});
        push_write(8'd7, rgb_of(8'd252, 8'd4, 8'd124));
        push_lookup({5'd15, 5'd0, 5'd31});
        push_lookup(15'h001F);
        push_lookup(15'h03E0);
        push_lookup(15'h7C00);
        push_write(8'd1, rgb_of(8'hFF, 8'h00, 8'hFF));
        push_lookup(15'h7C1F);
        push_pause();

        run_random(340);
        push_pause();
        // Refill from only three colors to get many ties across the palette.
        for (k = 0; k < 3; k++)
            few[k] = 24'($urandom_range(0, 24'hFFFFFF));
        for (k = 0; k < NUM_ENTRIES; k++)
            push_write(8'(k), few[$urandom_range(0, 2)]);
        run_random(340);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (req_queue.size() > 0 || s_tvalid);
        while (lookups_sent != results_seen)
            @(negedge clk);
        repeat (300) @(negedge clk);

        if (expected_best.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_best.size()));
        if (mismatch_count == 0)
            $display("nearest_palette_color_search_tb: PASS");
        else
            $display("nearest_palette_color_search_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/npcs_pkg.sv
sv/npcs_ram.sv
sv/npcs_match.sv
sv/nearest_palette_color_search.sv
tb/nearest_palette_color_search_tb.sv
